// ===== rtl/opc_pkg.sv =====
// shared types and constants for the ordinal permutation codec
// no dependencies; imported by the interfaces, the list cell and the top level
`default_nettype none

package opc_pkg;

	localparam int CITIES_DEF = 64;
	localparam int SYM_W      = 6;

	localparam logic MODE_DECODE = 1'b0;
	localparam logic MODE_ENCODE = 1'b1;

	typedef logic [SYM_W-1:0] sym_t;

	// control broadcast to every list cell
	typedef struct packed {
		logic mode;
		sym_t sym;
		logic restart;
		logic take;
		logic err;
		logic last;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/opc_if.sv =====
// valid/ready channel interfaces for the codec input and result beats
// depends on opc_pkg
`default_nettype none

interface opc_in_if;
	import opc_pkg::*;
	logic valid;
	logic ready;
	sym_t symbol;
	logic restart;
	modport source (output valid, output symbol, output restart, input ready);
	modport sink (input valid, input symbol, input restart, output ready);
endinterface

interface opc_out_if;
	import opc_pkg::*;
	logic valid;
	logic ready;
	sym_t value;
	logic error;
	logic last;
	modport source (output valid, output value, output error, output last, input ready);
	modport sink (input valid, input value, input error, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/opc_cell.sv =====
// one entry of the remaining-city list: match, select and shift toward cell 0
// depends on opc_pkg
`default_nettype none

module opc_cell #(
	parameter int Idx    = 0,
	parameter int Cities = opc_pkg::CITIES_DEF,
	parameter int CntW   = $clog2(Cities + 1)
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  opc_pkg::cell_ctrl_t    ctrl,
	input  wire  [CntW-1:0]        cnt,
	input  opc_pkg::sym_t          nb_entry,
	input  wire                    hit_in,
	output opc_pkg::sym_t          entry,
	output logic                   hit_out,
	output opc_pkg::sym_t          sel_value
);
	import opc_pkg::*;

	localparam sym_t IdxSym = sym_t'(Idx);

	sym_t entry_q;
	logic in_range;
	logic hit;

	// a restart beat sees the identity list
	assign entry    = ctrl.restart ? IdxSym : entry_q;
	assign in_range = CntW'(Idx) < cnt;
	assign hit      = in_range &&
		((ctrl.mode == MODE_ENCODE) ? (entry == ctrl.sym) : (IdxSym == ctrl.sym));
	assign hit_out  = hit_in | hit;
	assign sel_value = hit ? ((ctrl.mode == MODE_ENCODE) ? IdxSym : entry) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= IdxSym;
		end else if (ctrl.take) begin
			if (ctrl.last) begin
				entry_q <= IdxSym;
			end else if (ctrl.err) begin
				entry_q <= entry;
			end else begin
				// at or past the removed entry: take the neighbor's city
				entry_q <= hit_out ? nb_entry : entry;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ordinal_permutation_codec_top.sv =====
// top level of the ordinal permutation codec: mode register, row of list cells,
// result register; depends on opc_pkg, opc_if and opc_cell
//
// usage: write mode (0 decode ordinal->city, 1 encode city->ordinal) through
// cfg_we/cfg_wdata while idle. each beat on item carries a symbol and a restart
// flag; restart restores the identity list before the beat is handled. each
// accepted beat gives exactly one beat on result with value, error and last.
// result valid is registered and rises in the cycle after item acceptance;
// one item per cycle unless result stalls; the compare-and-shift spans the cell
// row. the result register frees item.ready in the same cycle the receiver
// takes the waiting beat; while result is stalled item.ready stays low.
// reset restores the identity list, the full count and decode mode, and
// empties the result register. a bad ordinal or absent city gives value 0,
// error 1 and leaves the list alone. last marks the final city of a tour,
// after which the list is back to identity.
`default_nettype none

module ordinal_permutation_codec_top #(
	parameter int Cities = opc_pkg::CITIES_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_we,
	input  wire             cfg_wdata,
	opc_in_if.sink          item,
	opc_out_if.source       result
);
	import opc_pkg::*;

	localparam int CntW = $clog2(Cities + 1);

	logic            mode_q;
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] cnt_eff;
	logic            take;
	logic            err;
	logic            last;
	cell_ctrl_t      ctrl;
	sym_t            sel_value;

	sym_t entries [Cities];
	sym_t sel_vals [Cities];
	logic hits [Cities];

	logic res_valid_q;
	sym_t value_q;
	logic error_q;
	logic last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DECODE;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	assign item.ready = !res_valid_q || result.ready;
	assign take       = item.valid && item.ready;
	assign cnt_eff    = item.restart ? CntW'(Cities) : cnt_q;
	assign err        = !hits[Cities-1];
	assign last       = !err && (cnt_eff == CntW'(1));

	assign ctrl = '{
		mode:    mode_q,
		sym:     item.symbol,
		restart: item.restart,
		take:    take,
		err:     err,
		last:    last
	};

	for (genvar i = 0; i < Cities; i++) begin : g_cell
		opc_cell #(
			.Idx    (i),
			.Cities (Cities),
			.CntW   (CntW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.cnt       (cnt_eff),
			.nb_entry  ((i + 1 < Cities) ? entries[(i + 1) % Cities] : entries[i]),
			.hit_in    ((i == 0) ? 1'b0 : hits[(i + Cities - 1) % Cities]),
			.entry     (entries[i]),
			.hit_out   (hits[i]),
			.sel_value (sel_vals[i])
		);
	end

	// at most one cell matches, so an or over the row selects it
	always_comb begin
		sel_value = '0;
		for (int i = 0; i < Cities; i++) begin
			sel_value = sel_value | sel_vals[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CntW'(Cities);
		end else if (take) begin
			if (last) begin
				cnt_q <= CntW'(Cities);
			end else if (err) begin
				cnt_q <= cnt_eff;
			end else begin
				cnt_q <= cnt_eff - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			value_q <= sel_value;
			error_q <= err;
			last_q  <= last;
		end
	end

	assign result.valid = res_valid_q;
	assign result.value = value_q;
	assign result.error = error_q;
	assign result.last  = last_q;

endmodule

`default_nettype wire
